[src/bssu_pkg.sv]
`timescale 1ns / 1ps
package bssu_pkg;

  localparam int MAX_COUNT_DEF = 64;
  localparam int SAMPLE_W      = 8;
  localparam int COUNT_OUT_W   = 7;
  localparam int SUM_W         = 14;
  localparam int DIV_STEP_W    = $clog2(SUM_W);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_STATS,
    ST_DRAIN
  } state_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

[src/bssu_cell.sv]
`timescale 1ns / 1ps
module bssu_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  bssu_pkg::cell_ctrl_t          ctrl,
  input  logic [bssu_pkg::SAMPLE_W-1:0] sample,
  input  logic [bssu_pkg::SAMPLE_W-1:0] left_value,
  input  logic                          left_valid,
  input  logic                          left_take,
  input  logic [bssu_pkg::SAMPLE_W-1:0] right_value,
  input  logic                          right_valid,
  output logic [bssu_pkg::SAMPLE_W-1:0] value,
  output logic                          valid,
  output logic                          take
);
  import bssu_pkg::*;

  logic [SAMPLE_W-1:0] value_next;
  logic                valid_next;

  // empty cells and smaller values give way to the new byte
  assign take = !valid || (sample > value);

  always_comb begin
    value_next = value;
    valid_next = valid;
    if (ctrl.shift) begin
      value_next = right_value;
      valid_next = right_valid;
    end else if (ctrl.insert && take) begin
      value_next = left_take ? left_value : sample;
      valid_next = valid || left_valid;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

[src/bssu_divider.sv]
`timescale 1ns / 1ps
module bssu_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [bssu_pkg::SUM_W-1:0]       dividend,
  input  logic [bssu_pkg::COUNT_OUT_W-1:0] divisor,
  output logic                             busy,
  output logic [bssu_pkg::SAMPLE_W-1:0]    quotient
);
  import bssu_pkg::*;

  // restoring divider, one quotient bit per cycle
  logic [SUM_W-1:0]       num;
  logic [COUNT_OUT_W-1:0] dsr;
  logic [COUNT_OUT_W-1:0] rem;
  logic [DIV_STEP_W-1:0]  step;
  logic [COUNT_OUT_W:0]   trial;
  logic                   fits;

  assign trial = {rem, num[SUM_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == DIV_STEP_W'(SUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      num      <= {num[SUM_W-2:0], 1'b0};
      rem      <= fits ? COUNT_OUT_W'(trial - {1'b0, dsr}) : COUNT_OUT_W'(trial);
      quotient <= {quotient[SAMPLE_W-2:0], fits};
    end
  end

endmodule

[src/byte_set_sort_statistics_unit.sv]
`timescale 1ns / 1ps
// Byte set sorter with statistics.
// Input channel (in_valid/in_ready): one byte per word, last_sample marks
// the final byte of a set. Bytes load at one word per cycle into a chain of
// MAX_COUNT insertion cells that keeps the set in descending order as it
// fills. Bytes beyond MAX_COUNT are dropped and flagged as overflowed.
// After the closing word the chain rotates once around to pick up maximum,
// minimum and the two middle values, while a bit-serial divider forms
// the mean.
// Output channel (out_valid/out_ready): one sorted byte per word, largest
// first, last_value on the final one; every word carries count, minimum,
// maximum, mean, median and the overflow flag. Words leave at one per cycle
// while out_ready is high; a stall simply holds the chain. Input is refused
// from the closing word until the last result is taken.
// Reset (rst, synchronous) empties the chain and starts a new set; no
// clearing pass is needed.
module byte_set_sort_statistics_unit #(
  parameter int MAX_COUNT = bssu_pkg::MAX_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bssu_pkg::SAMPLE_W-1:0]    sample,
  input  logic                             last_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bssu_pkg::SAMPLE_W-1:0]    sorted_value,
  output logic                             last_value,
  output logic [bssu_pkg::COUNT_OUT_W-1:0] set_count,
  output logic [bssu_pkg::SAMPLE_W-1:0]    minimum,
  output logic [bssu_pkg::SAMPLE_W-1:0]    maximum,
  output logic [bssu_pkg::SAMPLE_W-1:0]    mean,
  output logic [bssu_pkg::SAMPLE_W-1:0]    median,
  output logic                             overflowed
);
  import bssu_pkg::*;

  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int RW = $clog2(MAX_COUNT);

  state_t state, state_next;

  logic [CW-1:0]       count;
  logic [CW-1:0]       remain;
  logic [SUM_W-1:0]    sum;
  logic                overflow;
  logic [RW-1:0]       rot_k;
  logic                rot_done;
  logic [SAMPLE_W-1:0] max_r, min_r, med_a, med_b;
  logic [SAMPLE_W:0]   med_sum;

  logic       in_acc, out_acc, store_ok, rotate;
  logic [CW-1:0] count_next;
  logic       div_busy;
  cell_ctrl_t cell_ctrl;

  logic [SAMPLE_W-1:0] cell_value [MAX_COUNT];
  logic                cell_valid [MAX_COUNT];
  logic                cell_take  [MAX_COUNT];
  logic [SAMPLE_W-1:0] tail_value;
  logic                tail_valid;

  assign in_acc     = in_valid && in_ready;
  assign out_acc    = out_valid && out_ready;
  assign store_ok   = count < CW'(MAX_COUNT);
  assign count_next = count + CW'(store_ok);

  // --- insertion chain -------------------------------------------------
  // On rotation the tail refills from the head; when draining it refills
  // empty.
  assign tail_value = cell_value[0];
  assign tail_valid = rotate && cell_valid[0];

  for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_head
      bssu_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (cell_ctrl),
        .sample      (sample),
        .left_value  (sample),
        .left_valid  (1'b1),
        .left_take   (1'b0),
        .right_value ((MAX_COUNT == 1) ? tail_value : cell_value[(i+1) % MAX_COUNT]),
        .right_valid ((MAX_COUNT == 1) ? tail_valid : cell_valid[(i+1) % MAX_COUNT]),
        .value       (cell_value[i]),
        .valid       (cell_valid[i]),
        .take        (cell_take[i])
      );
    end else if (i == MAX_COUNT - 1) begin : g_tail
      bssu_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (cell_ctrl),
        .sample      (sample),
        .left_value  (cell_value[i-1]),
        .left_valid  (cell_valid[i-1]),
        .left_take   (cell_take[i-1]),
        .right_value (tail_value),
        .right_valid (tail_valid),
        .value       (cell_value[i]),
        .valid       (cell_valid[i]),
        .take        (cell_take[i])
      );
    end else begin : g_mid
      bssu_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (cell_ctrl),
        .sample      (sample),
        .left_value  (cell_value[i-1]),
        .left_valid  (cell_valid[i-1]),
        .left_take   (cell_take[i-1]),
        .right_value (cell_value[i+1]),
        .right_valid (cell_valid[i+1]),
        .value       (cell_value[i]),
        .valid       (cell_valid[i]),
        .take        (cell_take[i])
      );
    end
  end

  // --- mean ------------------------------------------------------------
  bssu_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc && last_sample),
    .dividend (sum + SUM_W'(store_ok ? sample : '0)),
    .divisor  (COUNT_OUT_W'(count_next)),
    .busy     (div_busy),
    .quotient (mean)
  );

  // --- control ---------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_acc && last_sample) begin
          state_next = ST_STATS;
        end
      end
      ST_STATS: begin
        if (rot_done && !div_busy) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc && remain == CW'(1)) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    out_valid        = 1'b0;
    rotate           = 1'b0;
    cell_ctrl.insert = 1'b0;
    cell_ctrl.shift  = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready         = 1'b1;
        cell_ctrl.insert = in_valid && store_ok;
      end
      ST_STATS: begin
        rotate          = 1'b1;
        cell_ctrl.shift = !rot_done;
      end
      ST_DRAIN: begin
        out_valid       = 1'b1;
        cell_ctrl.shift = out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      sum      <= '0;
      overflow <= 1'b0;
      rot_k    <= '0;
      rot_done <= 1'b0;
      remain   <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        count <= count_next;
        if (store_ok) begin
          sum <= sum + SUM_W'(sample);
        end else begin
          overflow <= 1'b1;
        end
        rot_k    <= '0;
        rot_done <= 1'b0;
        remain   <= count_next;
      end
      if (state == ST_STATS && !rot_done) begin
        rot_k <= rot_k + 1'b1;
        if (rot_k == RW'(MAX_COUNT - 1)) begin
          rot_done <= 1'b1;
        end
      end
      if (out_acc) begin
        remain <= remain - 1'b1;
        if (remain == CW'(1)) begin
          count    <= '0;
          sum      <= '0;
          overflow <= 1'b0;
        end
      end
    end
  end

  // head of the chain holds sorted[k] at rotation step k
  always_ff @(posedge clk) begin
    if (state == ST_STATS && !rot_done) begin
      if (rot_k == '0) begin
        max_r <= cell_value[0];
      end
      if (rot_k == RW'(count - CW'(1))) begin
        min_r <= cell_value[0];
      end
      if (rot_k == RW'(count >> 1)) begin
        med_a <= cell_value[0];
      end
      if (rot_k == RW'((count - CW'(1)) >> 1)) begin
        med_b <= cell_value[0];
      end
    end
  end

  assign med_sum      = {1'b0, med_a} + {1'b0, med_b};
  assign median       = med_sum[SAMPLE_W:1];
  assign sorted_value = cell_value[0];
  assign last_value   = remain == CW'(1);
  assign set_count    = COUNT_OUT_W'(count);
  assign minimum      = min_r;
  assign maximum      = max_r;
  assign overflowed   = overflow;

  // --- checks ----------------------------------------------------------
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");

  a_head_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cell_valid[0])
    else $error("result offered from an empty chain head");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_COUNT))
    else $error("stored count beyond capacity");

  a_set_clear: assert property (@(posedge clk) disable iff (rst)
    (out_acc && last_value) |=> (count == '0 && !overflow && in_ready))
    else $error("set not cleared after final result");

  a_remain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (remain != '0 && remain <= count))
    else $error("remaining result count out of range");

endmodule
